### rtl/core/cht_pkg.sv
// Shared types and constants for the two-table cuckoo hash set.
// Used by cuckoo_hash_table; depends on nothing else.
package cht_pkg;

    localparam int KEY_W   = 31;
    localparam int CFG_W   = 5;
    localparam int CFG_MAX = 2 ** CFG_W - 1;
    localparam int NN_W    = 2 * CFG_W;
    localparam int REM_W   = NN_W + 1;
    localparam int CNT_W   = $clog2(KEY_W);
    localparam int STAT_W  = 3;
    localparam int TBL_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int ACT_W   = 2;
    localparam int OUT_W   = 48;

    localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(7);

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND1   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FOUND2   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd4;
    localparam logic [STAT_W-1:0] STAT_ERASED   = 3'd5;

    localparam logic [TBL_W-1:0] TBL_NONE   = 2'd0;
    localparam logic [TBL_W-1:0] TBL_FIRST  = 2'd1;
    localparam logic [TBL_W-1:0] TBL_SECOND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_SQ,
        S_DIV_N,
        S_PROBE,
        S_SWAP,
        S_FETCH,
        S_MATCH,
        S_DONE
    } cht_state_t;

endpackage

### rtl/core/cuckoo_hash_table.sv
// Two-table cuckoo hash set with an iterative hash divider and two key memories.
// Depends on cht_pkg for codes, widths and the state type.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+-------------------------------------
//  s_        | in        | s_tvalid/s_tready  | s_tuser action, s_tdata key
//  m_        | out       | m_tvalid/m_tready  | m_tdata status..displacements
//  cfg_      | in        | cfg_we             | cfg_wdata slots_in_use
//
// One item at a time. A hash runs on the shared shift-subtract divider
// (31 steps for key mod N*N, then 5 steps split that into both slot indexes).
// A displaced key reuses its stored index when its stored hash tag matches N, else it is rehashed.
// Reset clears the valid bits of both tables at once; no clearing pass.
// A stalled result holds the output register while the next item runs and waits in S_DONE.
module cuckoo_hash_table
    import cht_pkg::*;
#(
    parameter int MAX_SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [30:0] key, [31] zero
    input  logic [ACT_W-1:0]  s_tuser,   // [1:0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [2:0] status, [4:3] which_table, [8:5] slot,
                                         // [39:9] dropped_key, [44:40] displacements
);

    // The slot count never exceeds the register range, so deeper tables are unreachable.
    localparam int DEPTH = (MAX_SLOTS < CFG_MAX) ? MAX_SLOTS : CFG_MAX;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = CFG_W + IDX_W + KEY_W;
    localparam logic [CFG_W-1:0] DEPTH_N = CFG_W'(DEPTH);

    cht_state_t state_reg, state_next;

    logic [CFG_W-1:0]  slots_reg;
    logic [CFG_W-1:0]  n_reg, n_next, n_eff;
    logic [NN_W-1:0]   nn_reg, nn_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  alt_reg, alt_next;
    logic              tsel_reg, tsel_next;
    logic [CFG_W-1:0]  moves_reg, moves_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [KEY_W-1:0]  dq_reg, dq_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEPTH-1:0]  valid1_reg, valid1_next;
    logic [DEPTH-1:0]  valid2_reg, valid2_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [TBL_W-1:0]  res_table_reg, res_table_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [KEY_W-1:0]  res_dropped_reg, res_dropped_next;
    logic [CFG_W-1:0]  res_moves_reg, res_moves_next;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic [ENT_W-1:0]  tab1_mem [DEPTH];
    logic [ENT_W-1:0]  tab2_mem [DEPTH];
    logic [ENT_W-1:0]  rd1_reg, rd2_reg, rd_sel, wr_ent;
    logic [IDX_W-1:0]  rd_addr2;
    logic              we1, we2;

    logic [REM_W-1:0]  div_d, trial, rem_step;
    logic              ge;
    logic [KEY_W-1:0]  dq_step;
    logic [IDX_W-1:0]  h1, h2;
    logic              vsel, hit1, hit2, accept, out_free;
    logic [KEY_W-1:0]  old_key;
    logic [IDX_W-1:0]  old_alt;
    logic [CFG_W-1:0]  old_tag;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        if (slots_reg == '0) begin
            n_eff = CFG_W'(1);
        end else if (slots_reg > DEPTH_N) begin
            n_eff = DEPTH_N;
        end else begin
            n_eff = slots_reg;
        end
    end

    // Shift-subtract divider step, shared by both hash phases.
    assign div_d    = (state_reg == S_DIV_SQ) ? {1'b0, nn_reg} : REM_W'(n_reg);
    assign trial    = {rem_reg[NN_W-1:0], dq_reg[KEY_W-1]};
    assign ge       = (trial >= div_d);
    assign rem_step = ge ? (trial - div_d) : trial;
    assign dq_step  = {dq_reg[KEY_W-2:0], ge};
    assign h1       = rem_step[IDX_W-1:0];
    assign h2       = dq_step[IDX_W-1:0];

    assign vsel     = tsel_reg ? valid2_reg[idx_reg] : valid1_reg[idx_reg];
    assign rd_sel   = tsel_reg ? rd2_reg : rd1_reg;
    assign old_key  = rd_sel[KEY_W-1:0];
    assign old_alt  = rd_sel[KEY_W +: IDX_W];
    assign old_tag  = rd_sel[ENT_W-1 -: CFG_W];
    assign wr_ent   = {n_reg, alt_reg, cur_reg};
    assign rd_addr2 = tsel_reg ? idx_reg : alt_reg;
    assign hit1     = valid1_reg[idx_reg] && (rd1_reg[KEY_W-1:0] == key_reg);
    assign hit2     = valid2_reg[alt_reg] && (rd2_reg[KEY_W-1:0] == key_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == ACT_INSERT || s_tuser == ACT_LOOKUP ||
                        s_tuser == ACT_ERASE) begin
                        state_next = S_DIV_SQ;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV_SQ: begin
                if (cnt_reg == '0) begin
                    state_next = S_DIV_N;
                end
            end
            S_DIV_N: begin
                if (cnt_reg == '0) begin
                    state_next = (act_reg == ACT_INSERT) ? S_PROBE : S_FETCH;
                end
            end
            S_PROBE: begin
                if (moves_reg >= n_reg || !vsel) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP: begin
                state_next = (old_tag == n_reg) ? S_PROBE : S_DIV_SQ;
            end
            S_FETCH: state_next = S_MATCH;
            S_MATCH: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready         = (state_reg == S_IDLE);
        n_next           = n_reg;
        nn_next          = nn_reg;
        act_next         = act_reg;
        key_next         = key_reg;
        cur_next         = cur_reg;
        idx_next         = idx_reg;
        alt_next         = alt_reg;
        tsel_next        = tsel_reg;
        moves_next       = moves_reg;
        rem_next         = rem_reg;
        dq_next          = dq_reg;
        cnt_next         = cnt_reg;
        valid1_next      = valid1_reg;
        valid2_next      = valid2_reg;
        res_status_next  = res_status_reg;
        res_table_next   = res_table_reg;
        res_slot_next    = res_slot_reg;
        res_dropped_next = res_dropped_reg;
        res_moves_next   = res_moves_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        we1              = 1'b0;
        we2              = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next         = s_tuser;
                    key_next         = s_tdata[KEY_W-1:0];
                    cur_next         = s_tdata[KEY_W-1:0];
                    dq_next          = s_tdata[KEY_W-1:0];
                    rem_next         = '0;
                    cnt_next         = CNT_W'(KEY_W - 1);
                    n_next           = n_eff;
                    nn_next          = NN_W'(n_eff) * NN_W'(n_eff);
                    moves_next       = '0;
                    tsel_next        = 1'b0;
                    res_status_next  = STAT_MISSING;
                    res_table_next   = TBL_NONE;
                    res_slot_next    = '0;
                    res_dropped_next = '0;
                    res_moves_next   = '0;
                end
            end
            S_DIV_SQ: begin
                cnt_next = cnt_reg - CNT_W'(1);
                rem_next = rem_step;
                dq_next  = dq_step;
                if (cnt_reg == '0) begin
                    // key mod N*N is below N*32, so its upper bits already sit below N.
                    rem_next = REM_W'(rem_step[NN_W-1:CFG_W]);
                    dq_next  = {rem_step[CFG_W-1:0], {(KEY_W - CFG_W){1'b0}}};
                    cnt_next = CNT_W'(CFG_W - 1);
                end
            end
            S_DIV_N: begin
                cnt_next = cnt_reg - CNT_W'(1);
                rem_next = rem_step;
                dq_next  = dq_step;
                if (cnt_reg == '0) begin
                    idx_next = tsel_reg ? h2 : h1;
                    alt_next = tsel_reg ? h1 : h2;
                end
            end
            S_PROBE: begin
                if (moves_reg >= n_reg) begin
                    res_status_next  = STAT_DROPPED;
                    res_dropped_next = cur_reg;
                    res_moves_next   = moves_reg;
                end else if (!vsel) begin
                    we1             = !tsel_reg;
                    we2             = tsel_reg;
                    if (tsel_reg) begin
                        valid2_next[idx_reg] = 1'b1;
                    end else begin
                        valid1_next[idx_reg] = 1'b1;
                    end
                    res_status_next = STAT_INSERTED;
                    res_moves_next  = moves_reg;
                end
            end
            S_SWAP: begin
                we1        = !tsel_reg;
                we2        = tsel_reg;
                moves_next = moves_reg + CFG_W'(1);
                tsel_next  = !tsel_reg;
                cur_next   = old_key;
                if (old_tag == n_reg) begin
                    // The evicted key's other index was stored with it.
                    idx_next = old_alt;
                    alt_next = idx_reg;
                end else begin
                    rem_next = '0;
                    dq_next  = old_key;
                    cnt_next = CNT_W'(KEY_W - 1);
                end
            end
            S_FETCH: begin
            end
            S_MATCH: begin
                if (hit1) begin
                    res_table_next = TBL_FIRST;
                    res_slot_next  = SLOT_W'(idx_reg);
                    if (act_reg == ACT_ERASE) begin
                        valid1_next[idx_reg] = 1'b0;
                        res_status_next      = STAT_ERASED;
                    end else begin
                        res_status_next = STAT_FOUND1;
                    end
                end else if (hit2) begin
                    res_table_next = TBL_SECOND;
                    res_slot_next  = SLOT_W'(alt_reg);
                    if (act_reg == ACT_ERASE) begin
                        valid2_next[alt_reg] = 1'b0;
                        res_status_next      = STAT_ERASED;
                    end else begin
                        res_status_next = STAT_FOUND2;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, res_moves_reg, res_dropped_reg, res_slot_reg,
                                      res_table_reg, res_status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            slots_reg     <= SLOTS_RESET;
            valid1_reg    <= '0;
            valid2_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid1_reg    <= valid1_next;
            valid2_reg    <= valid2_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                slots_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg           <= n_next;
        nn_reg          <= nn_next;
        act_reg         <= act_next;
        key_reg         <= key_next;
        cur_reg         <= cur_next;
        idx_reg         <= idx_next;
        alt_reg         <= alt_next;
        tsel_reg        <= tsel_next;
        moves_reg       <= moves_next;
        rem_reg         <= rem_next;
        dq_reg          <= dq_next;
        cnt_reg         <= cnt_next;
        res_status_reg  <= res_status_next;
        res_table_reg   <= res_table_next;
        res_slot_reg    <= res_slot_next;
        res_dropped_reg <= res_dropped_next;
        res_moves_reg   <= res_moves_next;
        out_data_reg    <= out_data_next;
    end

    // Each table entry: key, the key's index in the other table, and the N it was hashed with.
    always_ff @(posedge aclk) begin
        if (we1) begin
            tab1_mem[idx_reg] <= wr_ent;
        end
        rd1_reg <= tab1_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (we2) begin
            tab2_mem[idx_reg] <= wr_ent;
        end
        rd2_reg <= tab2_mem[rd_addr2];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in flight");

    a_moves_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> moves_reg <= n_reg)
        else $error("displacement count ran past the slot count");

    a_swap_occupied: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SWAP |-> vsel)
        else $error("eviction from an empty slot");

endmodule

### tb/sv/cuckoo_hash_table_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cuckoo_hash_table: directed and random insert, lookup, erase and unknown
// action items over several slot counts, checked against a shadow pair of tables kept here.
// Depends on cht_pkg and the cuckoo_hash_table RTL.
module cuckoo_hash_table_tb
    import cht_pkg::*;
();

    localparam int NSLOT         = 16;
    localparam int LIMIT_CYCLES  = 1500000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int HOLD_AT_ITEM  = 215;
    localparam int SETTLE_CYCLES = 60;
    localparam int TAIL_CYCLES   = 100;
    localparam int MAX_SHOWN     = 10;
    localparam int CALM_BACKLOG  = 60;

    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {JOB_ITEM, JOB_SLOTS, JOB_DRAIN} job_kind_t;

    typedef struct {
        job_kind_t        kind;
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [CFG_W-1:0] slots;
    } job_t;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [TBL_W-1:0]  tbl;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  dropped;
        logic [4:0]        moves;
    } reply_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;    // [30:0] key, [31] zero
    logic [ACT_W-1:0] s_tuser   = '0;    // [1:0] action
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [OUT_W-1:0] m_tdata;           // [2:0] status, [4:3] which_table, [8:5] slot,
                                         // [39:9] dropped_key, [44:40] displacements

    // Shadow copy of both tables and the slot count register.
    logic [KEY_W-1:0] keys_one [NSLOT];
    logic [KEY_W-1:0] keys_two [NSLOT];
    logic             used_one [NSLOT];
    logic             used_two [NSLOT];
    logic [CFG_W-1:0] shadow_slots;

    job_t        backlog[$];
    reply_t      replies_due[$];
    int          mismatches = 0;
    int unsigned cycle_no   = 0;
    int          send_gap   = 0;
    int          recv_gap   = 0;
    int          quiet      = 0;
    logic        calm       = 1'b0;
    logic        hold_off   = 1'b0;
    logic        hold_used  = 1'b0;
    int          hold_left  = 0;
    int          taken_in   = 0;

    cuckoo_hash_table #(
        .MAX_SLOTS(NSLOT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Zero acts as one slot, anything above the table depth as the full depth.
    function automatic int unsigned slots_used(logic [CFG_W-1:0] v);
        int unsigned n;
        n = v;
        if (n == 0) n = 1;
        if (n > NSLOT) n = NSLOT;
        return n;
    endfunction

    // Applies one item to the shadow tables and queues the reply it should produce.
    function automatic void predict_reply(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key);
        int unsigned      n;
        int unsigned      idx;
        logic [KEY_W-1:0] moving;
        logic [KEY_W-1:0] old;
        logic             to_first;
        logic             done;
        reply_t           r;
        n = slots_used(shadow_slots);
        r.status  = STAT_MISSING;
        r.tbl     = TBL_NONE;
        r.slot    = '0;
        r.dropped = '0;
        r.moves   = '0;
        if (action == ACT_INSERT) begin
            moving   = key;
            to_first = 1'b1;
            done     = 1'b0;
            r.status = STAT_INSERTED;
            while (!done) begin
                if (r.moves >= n) begin
                    r.status  = STAT_DROPPED;
                    r.dropped = moving;
                    done      = 1'b1;
                end else if (to_first) begin
                    idx = moving % n;
                    if (!used_one[idx]) begin
                        keys_one[idx] = moving;
                        used_one[idx] = 1'b1;
                        done          = 1'b1;
                    end else begin
                        old           = keys_one[idx];
                        keys_one[idx] = moving;
                        moving        = old;
                        r.moves++;
                        to_first      = 1'b0;
                    end
                end else begin
                    idx = (moving / n) % n;
                    if (!used_two[idx]) begin
                        keys_two[idx] = moving;
                        used_two[idx] = 1'b1;
                        done          = 1'b1;
                    end else begin
                        old           = keys_two[idx];
                        keys_two[idx] = moving;
                        moving        = old;
                        r.moves++;
                        to_first      = 1'b1;
                    end
                end
            end
        end else if (action == ACT_LOOKUP || action == ACT_ERASE) begin
            idx = key % n;
            if (used_one[idx] && keys_one[idx] == key) begin
                r.status = STAT_FOUND1;
                r.tbl    = TBL_FIRST;
                r.slot   = SLOT_W'(idx);
            end else begin
                idx = (key / n) % n;
                if (used_two[idx] && keys_two[idx] == key) begin
                    r.status = STAT_FOUND2;
                    r.tbl    = TBL_SECOND;
                    r.slot   = SLOT_W'(idx);
                end
            end
            if (action == ACT_ERASE && r.tbl != TBL_NONE) begin
                r.status = STAT_ERASED;
                if (r.tbl == TBL_FIRST) used_one[r.slot] = 1'b0;
                else used_two[r.slot] = 1'b0;
            end
        end
        replies_due.push_back(r);
    endfunction

    function automatic void check_reply(logic [OUT_W-1:0] word);
        reply_t want;
        reply_t got;
        got.status  = word[2:0];
        got.tbl     = word[4:3];
        got.slot    = word[8:5];
        got.dropped = word[39:9];
        got.moves   = word[44:40];
        if (replies_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("reply %h arrived with none outstanding", word);
        end else begin
            want = replies_due.pop_front();
            if (got.status !== want.status || got.tbl !== want.tbl || got.slot !== want.slot
                    || got.dropped !== want.dropped || got.moves !== want.moves) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("mismatch: want status %0d table %0d slot %0d dropped %0d moves %0d",
                             want.status, want.tbl, want.slot, want.dropped, want.moves);
                    $display("          got  status %0d table %0d slot %0d dropped %0d moves %0d",
                             got.status, got.tbl, got.slot, got.dropped, got.moves);
                end
            end
        end
    endfunction

    task automatic queue_item(logic [ACT_W-1:0] action, logic [KEY_W-1:0] key);
        backlog.push_back('{kind: JOB_ITEM, action: action, key: key, slots: '0});
    endtask

    task automatic queue_slots(logic [CFG_W-1:0] v);
        backlog.push_back('{kind: JOB_SLOTS, action: ACT_LOOKUP, key: '0, slots: v});
    endtask

    // Driver: one new item, slot count write or drain step per free cycle.
    always @(posedge aclk) begin
        job_t head;
        logic offer;
        logic write_now;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            cfg_we   <= 1'b0;
            send_gap = 0;
            quiet    = 0;
        end else begin
            offer     = s_tvalid && !s_tready;
            write_now = 1'b0;
            if (s_tvalid && s_tready) predict_reply(s_tuser, s_tdata[KEY_W-1:0]);
            if (replies_due.size() == 0 && !s_tvalid) quiet++;
            else quiet = 0;
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (backlog.size() > 0) begin
                    head = backlog[0];
                    case (head.kind)
                        JOB_ITEM: begin
                            if (!calm && $urandom_range(0, 5) == 0) begin
                                send_gap = $urandom_range(1, 15) - 1;
                            end else begin
                                void'(backlog.pop_front());
                                offer = 1'b1;
                                s_tuser <= head.action;
                                s_tdata <= {1'b0, head.key};
                            end
                        end
                        JOB_SLOTS: begin
                            // The block is idle once every reply is in; let it settle first.
                            if (quiet >= SETTLE_CYCLES) begin
                                void'(backlog.pop_front());
                                write_now = 1'b1;
                                cfg_wdata <= head.slots;
                                shadow_slots = head.slots;
                            end
                        end
                        default: begin
                            if (quiet > 0) void'(backlog.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid <= offer;
            cfg_we   <= write_now;
            calm     <= backlog.size() < CALM_BACKLOG;
        end
    end

    // Monitor: checks each reply and stalls the result channel in random bursts.
    always @(posedge aclk) begin
        logic take;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_tvalid && m_tready) check_reply(m_tdata);
            take = 1'b0;
            if (hold_off) begin
                take = 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(1, 15) - 1;
            end else begin
                take = 1'b1;
            end
            m_tready <= take;
        end
    end

    // One long hold-off on the result side so the block backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_off  <= 1'b0;
            hold_used <= 1'b0;
            hold_left <= 0;
            taken_in  <= 0;
        end else begin
            if (s_tvalid && s_tready) taken_in <= taken_in + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                hold_off  <= hold_left > 1;
            end else if (!hold_used && taken_in == HOLD_AT_ITEM) begin
                hold_off  <= 1'b1;
                hold_used <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_no++;
        if (cycle_no >= LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] plan [10];
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        logic [ACT_W-1:0] act;
        int unsigned      nv;
        int unsigned      pick;

        for (int i = 0; i < NSLOT; i++) begin
            used_one[i] = 1'b0;
            used_two[i] = 1'b0;
            keys_one[i] = '0;
            keys_two[i] = '0;
        end
        shadow_slots = SLOTS_RESET;

        // Directed part at the reset slot count of seven: misses, chains, erases, unknown actions.
        queue_item(ACT_LOOKUP, 31'd5);
        queue_item(ACT_ERASE, 31'd5);
        queue_item(ACT_INSERT, 31'd0);
        queue_item(ACT_INSERT, '1);
        queue_item(ACT_LOOKUP, '1);
        queue_item(ACT_INSERT, 31'd7);
        queue_item(ACT_INSERT, 31'd14);
        queue_item(ACT_LOOKUP, 31'd0);
        queue_item(ACT_LOOKUP, 31'd7);
        queue_item(ACT_ERASE, 31'd7);
        queue_item(ACT_LOOKUP, 31'd7);
        queue_item(ACT_ERASE, 31'd14);
        queue_item(ACT_UNKNOWN, 31'd0);
        queue_item(ACT_UNKNOWN, '1);
        queue_item(ACT_INSERT, 31'd49);
        queue_item(ACT_INSERT, 31'd56);
        // A slot count of zero behaves as one slot, so every collision drops a key.
        queue_slots('0);
        queue_item(ACT_INSERT, 31'd3);
        queue_item(ACT_INSERT, 31'd9);
        queue_item(ACT_LOOKUP, 31'd9);
        queue_item(ACT_LOOKUP, '1);
        queue_item(ACT_ERASE, 31'd9);
        queue_item(ACT_INSERT, '1);
        queue_item(ACT_INSERT, 31'd1);

        plan = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd3, 5'd5, 5'd16, 5'd9, 5'd12, 5'd4};
        foreach (plan[p]) begin
            queue_slots(plan[p]);
            nv = slots_used(plan[p]);
            for (int i = 0; i < 43; i++) begin
                if (p == 2 && i == 20) begin
                    backlog.push_back('{kind: JOB_DRAIN, action: ACT_LOOKUP, key: '0, slots: '0});
                end
                pick = $urandom_range(0, 99);
                if (pick < 45) act = ACT_INSERT;
                else if (pick < 72) act = ACT_LOOKUP;
                else if (pick < 95) act = ACT_ERASE;
                else act = ACT_UNKNOWN;
                // Mostly keys queued for insert earlier or packed into few slots, so chains form.
                pick = $urandom_range(0, 99);
                if (pick < 50 && key_pool.size() > 0) begin
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                end else if (pick < 80) begin
                    key = KEY_W'($urandom_range(0, 3 * nv * nv));
                end else if (pick < 95) begin
                    key = KEY_W'($urandom());
                end else if (pick < 97) begin
                    key = '0;
                end else if (pick < 99) begin
                    key = '1;
                end else begin
                    key = KEY_W'(nv * nv * $urandom_range(1, 1000000));
                end
                if (act == ACT_INSERT) begin
                    key_pool.push_back(key);
                    if (key_pool.size() > 24) void'(key_pool.pop_front());
                end
                queue_item(act, key);
            end
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (backlog.size() != 0 || s_tvalid || replies_due.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
